// ----- hw/rtl/ssd_pkg.sv -----
`default_nettype none
package ssd_pkg;

    localparam int COST_W        = 40;
    localparam int WGT_W         = 16;
    localparam int PRICE_W       = 16;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int MAX_WEEKS_DEF = 64;

    // Register index, taken from paddr[2]
    localparam logic REG_RATE  = 1'b0;
    localparam logic REG_PRICE = 1'b1;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_MUL,
        ALU_LT
    } alu_op_t;

    typedef struct packed {
        alu_op_t             op;
        logic [COST_W-1:0]   a;
        logic [COST_W-1:0]   b;
    } alu_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ssd_alu.sv -----
`default_nettype none
module ssd_alu
    import ssd_pkg::*;
(
    input  wire logic              aclk,
    input  wire alu_req_t          req,
    output logic [COST_W-1:0]      res,
    output logic                   lt
);

    logic [COST_W-1:0] res_reg;
    logic              lt_reg;
    logic [2*WGT_W-1:0] prod;

    assign prod = req.a[WGT_W-1:0] * req.b[WGT_W-1:0];

    always_ff @(posedge aclk) begin
        lt_reg <= (req.a < req.b);
        unique case (req.op)
            ALU_MUL: res_reg <= COST_W'(prod);
            ALU_ADD: res_reg <= req.a + req.b;
            ALU_LT:  res_reg <= res_reg;
            default: res_reg <= res_reg;
        endcase
    end

    assign res = res_reg;
    assign lt  = lt_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/ssd_bit_store.sv -----
`default_nettype none
module ssd_bit_store
    import ssd_pkg::*;
#(
    parameter int DEPTH = MAX_WEEKS_DEF,
    parameter int AW    = $clog2(MAX_WEEKS_DEF)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic          wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic               rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/shipping_schedule_dp.sv -----
// Each week word steps through multiply, two adds, compare and decide, using the
//   shared ALU; s_tready is low for that time, so no new week is taken meanwhile.
// After the last week: traceback reads the decision store (read port) and writes the
//   block store per schedule block, then each block word is read and waits out any m_tready stall.
// Reset (aresetn, synchronous, active low) clears the sequencer, cost history and week
//   count and sets both prices to 1; the decision and block stores are not cleared.
`default_nettype none
module shipping_schedule_dp
    import ssd_pkg::*;
#(
    parameter int MAX_WEEKS = MAX_WEEKS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input week words
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] weight
    input  wire logic                  s_tlast,   // last_week
    // Schedule block words
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [39:0]                m_tdata,   // [39:0] total_cost
    output logic                       m_tuser,   // [0] choice
    output logic                       m_tlast,   // last_block
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int IDX_W = $clog2(MAX_WEEKS);
    localparam int CNT_W = $clog2(MAX_WEEKS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD_A,
        ST_ADD_B,
        ST_CMP,
        ST_DECIDE,
        ST_TRACE_RD,
        ST_TRACE_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    state_t             state_reg;
    logic [PRICE_W-1:0] rate_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [WGT_W-1:0]   weight_reg;
    logic               last_reg;
    logic [COST_W-1:0]  hist_reg [4];
    logic [COST_W-1:0]  ca_reg;
    logic [COST_W-1:0]  cb_reg;
    logic [COST_W-1:0]  total_cost_reg;
    logic [IDX_W-1:0]   week_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic               last_block_reg;

    alu_req_t           alu_req;
    logic [COST_W-1:0]  alu_res;
    logic               alu_lt;

    logic               cfg_wr;
    logic               pick;
    logic [COST_W-1:0]  cost;
    logic               seq_end;
    logic               dec_rdata;
    logic               blk_rdata;
    logic [2:0]         step;
    logic               trace_done;

    // APB: always ready, register picked by paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_PRICE) ? APB_DATA_W'(price_reg) : APB_DATA_W'(rate_reg);

    // Shared ALU requests, one per arithmetic step of a week
    always_comb begin
        alu_req.op = ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (state_reg)
            ST_MUL: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = COST_W'(rate_reg);
                alu_req.b  = COST_W'(weight_reg);
            end
            ST_ADD_A: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = hist_reg[0];
                alu_req.b  = alu_res;
            end
            ST_ADD_B: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = hist_reg[3];
                alu_req.b  = COST_W'(price_reg) << 2;
            end
            ST_CMP: begin
                alu_req.op = ALU_LT;
                alu_req.a  = ca_reg;
                alu_req.b  = alu_res;
            end
            default: begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    ssd_alu u_alu (
        .aclk (aclk),
        .req  (alu_req),
        .res  (alu_res),
        .lt   (alu_lt)
    );

    // Weeks 0 to 2 are forced to A; ties go to B
    assign pick    = (week_reg >= IDX_W'(3)) && !alu_lt;
    assign cost    = pick ? cb_reg : ca_reg;
    assign seq_end = last_reg || (week_reg == IDX_W'(MAX_WEEKS - 1));

    ssd_bit_store #(.DEPTH(MAX_WEEKS), .AW(IDX_W)) u_dec_store (
        .aclk  (aclk),
        .we    (state_reg == ST_DECIDE),
        .waddr (week_reg),
        .wdata (pick),
        .re    (state_reg == ST_TRACE_RD),
        .raddr (idx_reg),
        .rdata (dec_rdata)
    );

    // Traceback step: back four weeks over a contract, one over a single week
    assign step       = dec_rdata ? 3'd4 : 3'd1;
    assign trace_done = ({1'b0, idx_reg} < (IDX_W + 1)'(step))
                        || (count_reg == CNT_W'(MAX_WEEKS - 1));

    // Blocks stack up in reverse order, then pop out forward
    ssd_bit_store #(.DEPTH(MAX_WEEKS), .AW(IDX_W)) u_blk_store (
        .aclk  (aclk),
        .we    (state_reg == ST_TRACE_WR),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (dec_rdata),
        .re    (state_reg == ST_EMIT_RD),
        .raddr (rd_ptr_reg),
        .rdata (blk_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rate_reg       <= PRICE_W'(1);
            price_reg      <= PRICE_W'(1);
            week_reg       <= '0;
            count_reg      <= '0;
            last_block_reg <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                hist_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_RATE:  rate_reg  <= pwdata[PRICE_W-1:0];
                    REG_PRICE: price_reg <= pwdata[PRICE_W-1:0];
                    default:   rate_reg  <= rate_reg;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        weight_reg <= s_tdata[WGT_W-1:0];
                        last_reg   <= s_tlast;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_MUL:   state_reg <= ST_ADD_A;
                ST_ADD_A: state_reg <= ST_ADD_B;
                ST_ADD_B: begin
                    // hold option A's cost while the ALU forms option B's
                    ca_reg    <= alu_res;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    cb_reg    <= alu_res;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (seq_end) begin
                        // start a fresh sequence; keep the final cost for every block
                        total_cost_reg <= cost;
                        idx_reg        <= week_reg;
                        count_reg      <= '0;
                        week_reg       <= '0;
                        for (int k = 0; k < 4; k++) begin
                            hist_reg[k] <= '0;
                        end
                        state_reg      <= ST_TRACE_RD;
                    end else begin
                        hist_reg[3] <= hist_reg[2];
                        hist_reg[2] <= hist_reg[1];
                        hist_reg[1] <= hist_reg[0];
                        hist_reg[0] <= cost;
                        week_reg    <= week_reg + IDX_W'(1);
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_TRACE_RD: state_reg <= ST_TRACE_WR;
                ST_TRACE_WR: begin
                    count_reg <= count_reg + CNT_W'(1);
                    idx_reg   <= idx_reg - IDX_W'(step);
                    if (trace_done) begin
                        rd_ptr_reg <= count_reg[IDX_W-1:0];
                        state_reg  <= ST_EMIT_RD;
                    end else begin
                        state_reg  <= ST_TRACE_RD;
                    end
                end
                ST_EMIT_RD: begin
                    last_block_reg <= (rd_ptr_reg == '0);
                    state_reg      <= ST_EMIT_OUT;
                end
                ST_EMIT_OUT: begin
                    if (m_tready) begin
                        if (last_block_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            rd_ptr_reg <= rd_ptr_reg - IDX_W'(1);
                            state_reg  <= ST_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT_OUT);
    assign m_tdata  = total_cost_reg;
    assign m_tuser  = blk_rdata;
    assign m_tlast  = last_block_reg;

    // Never take a week while a block word is on offer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output both active");

    // A week word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after accepting a week");

    // The final block word returns the block to idle
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("not idle after final block");

    // Traceback never collects more blocks than weeks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TRACE_WR) |-> (count_reg < CNT_W'(MAX_WEEKS)))
        else $error("traceback count overrun");

endmodule
`default_nettype wire
